// ----- rtl/core/sorted_priority_queue_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Beat types, record and link structs, and the status and operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int SPQ_DEPTH = 16;
    localparam int KEY_W     = 16;
    localparam int TIME_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [KEY_W-1:0]  new_id;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] service_time;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    out_id;
        logic [TIME_W-1:0]   out_arrival;
        logic [TIME_W-1:0]   out_service;
        logic [OCC_W-1:0]    occupancy;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] service;
    } rec_t;

    // Broadcast from the control to every cell.
    typedef struct packed {
        logic insert_en;
        logic pop_en;
        rec_t rec;
    } spq_cmd_t;

    // What a cell shows its neighbors.
    typedef struct packed {
        rec_t rec;
        logic valid;
        logic keep;
    } spq_link_t;

    // The head sees a virtual neighbor that always keeps, the tail one that is empty.
    localparam spq_link_t LINK_HEAD = '{rec: '0, valid: 1'b1, keep: 1'b1};
    localparam spq_link_t LINK_TAIL = '{rec: '0, valid: 1'b0, keep: 1'b0};

endpackage

`default_nettype wire

// ----- rtl/core/sorted_priority_queue_unit.sv -----
// One request beat per clock is taken while the response register is empty
// or being drained; each insert or pop updates a row of QUEUE_DEPTH cells in
// parallel, every cell comparing its own key with the new one and shifting
// from a neighbor, so the response is registered in the cycle after the request
// and, while responses drain, the queue sustains one beat per clock with no clearing pass.
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded queue of process records in ascending id order; pop returns the
// smallest id, and a new record goes ahead of stored records with equal id.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_priority_queue_unit_macros.svh"

module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = SPQ_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    spq_link_t             cell_out [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] vld_vec;
    spq_cmd_t              cmd;
    logic                  accept;
    logic                  full;
    logic                  empty;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign full      = vld_vec[QUEUE_DEPTH-1];
    assign empty     = !vld_vec[0];

    assign cmd.insert_en   = accept && (req.operation == OP_INSERT) && !full;
    assign cmd.pop_en      = accept && (req.operation == OP_POP) && !empty;
    assign cmd.rec.key     = req.new_id;
    assign cmd.rec.arrival = req.arrival_time;
    assign cmd.rec.service = req.service_time;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        spq_link_t prev_link;
        spq_link_t next_link;

        if (i == 0)
        begin : g_head
            assign prev_link = LINK_HEAD;
        end
        else
        begin : g_mid_prev
            assign prev_link = cell_out[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign next_link = LINK_TAIL;
        end
        else
        begin : g_mid_next
            assign next_link = cell_out[i+1];
        end

        spq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .prev  (prev_link),
            .next  (next_link),
            .self  (cell_out[i])
        );

        assign vld_vec[i] = cell_out[i].valid;
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp_next           = rsp_reg;
        rsp_next.status    = ST_OK;
        rsp_next.out_id    = '0;
        rsp_next.out_arrival = '0;
        rsp_next.out_service = '0;
        rsp_next.occupancy = OCC_W'(count_next);
        if (req.operation == OP_INSERT)
        begin
            if (full)
            begin
                rsp_next.status = ST_FULL;
            end
        end
        else if (empty)
        begin
            rsp_next.status = ST_EMPTY;
        end
        else
        begin
            rsp_next.out_id      = cell_out[0].rec.key;
            rsp_next.out_arrival = cell_out[0].rec.arrival;
            rsp_next.out_service = cell_out[0].rec.service;
        end
    end

    assign rsp_valid_next = accept || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The cell valid bits must match the fill count, and the head must be sorted.
    `SPQ_ASSERT_NOW(a_count_matches_cells, 1'b1, $countones(vld_vec) == count_reg, "cell valid bits disagree with count")
    `SPQ_ASSERT_NOW(a_head_sorted, vld_vec[1], cell_out[0].rec.key <= cell_out[1].rec.key, "head cells out of order")
    `SPQ_ASSERT_NEXT(a_pop_returns_head, cmd.pop_en, rsp.out_id == $past(cell_out[0].rec.key), "pop did not return head key")
    `SPQ_ASSERT_NEXT(a_insert_grows, cmd.insert_en, count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow the queue")

endmodule

`default_nettype wire

// ----- rtl/core/spq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one record; on insert it keeps, takes the new record or shifts in
// from the cell ahead, and on pop it shifts in from the cell behind.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire spq_cmd_t  cmd,
    input  wire spq_link_t prev,
    input  wire spq_link_t next,
    output spq_link_t      self
);

    rec_t rec_reg;
    rec_t rec_next;
    logic vld_reg;
    logic vld_next;
    logic keep;

    // A valid record strictly below the new key stays; equal keys move back.
    assign keep = vld_reg && (rec_reg.key < cmd.rec.key);

    always_comb
    begin
        rec_next = rec_reg;
        vld_next = vld_reg;
        if (cmd.insert_en)
        begin
            if (!keep)
            begin
                if (prev.keep)
                begin
                    rec_next = cmd.rec;
                    vld_next = 1'b1;
                end
                else
                begin
                    rec_next = prev.rec;
                    vld_next = prev.valid;
                end
            end
        end
        else if (cmd.pop_en)
        begin
            rec_next = next.rec;
            vld_next = next.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign self.rec   = rec_reg;
    assign self.valid = vld_reg;
    assign self.keep  = keep;

endmodule

`default_nettype wire
